### design/conrec_pkg.sv
// Shared types, constants and lookup tables for the contour segment block.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps

package conrec_pkg;

  localparam int SampleBits   = 16;
  localparam int FracBits     = 8;
  localparam int MaxCols      = 4096;
  localparam int MaxRows      = 4096;
  localparam int MaxLevels    = 6;
  localparam int ColBits      = $clog2(MaxCols);
  localparam int RowIdxBits   = $clog2(MaxRows);
  localparam int RowBits      = RowIdxBits + 1;
  localparam int WidthBits    = 13;
  localparam int CountBits    = 3;
  localparam int LevelIdxBits = 3;
  localparam int CoordBits    = 20;
  localparam int TriCount     = 4;
  localparam int SlotCount    = MaxLevels * TriCount;
  localparam int SlotBits     = $clog2(SlotCount);
  localparam int CellFifoDepth = 4;

  typedef logic signed [SampleBits-1:0] sample_t;

  typedef struct packed {
    sample_t               s1;   // upper left
    sample_t               s2;   // upper right
    sample_t               s3;   // lower right (current)
    sample_t               s4;   // lower left
    logic [ColBits-1:0]    ci;   // cell column
    logic [RowIdxBits-1:0] cj;   // cell row
  } cell_t;

  typedef struct packed {
    logic [CountBits-1:0]          level_count;
    logic [MaxLevels-1:0][SampleBits-1:0] levels;
  } cfg_t;

  typedef enum logic [1:0] {
    SgNeg  = 2'd0,
    SgZero = 2'd1,
    SgPos  = 2'd2
  } sign_e;

  // corner sign triple -> segment case
  localparam logic [3:0] CaseTable [27] = '{
    4'd0, 4'd0, 4'd8,  4'd0, 4'd2, 4'd5,  4'd7, 4'd6, 4'd9,
    4'd0, 4'd3, 4'd4,  4'd1, 4'd3, 4'd1,  4'd4, 4'd3, 4'd0,
    4'd9, 4'd6, 4'd7,  4'd5, 4'd2, 4'd0,  4'd8, 4'd0, 4'd0
  };

  // segment case -> {a0, a1, b0, b1} local triangle vertices
  localparam logic [7:0] SegTable [10] = '{
    {2'd0, 2'd0, 2'd0, 2'd0},
    {2'd0, 2'd0, 2'd1, 2'd1}, {2'd1, 2'd1, 2'd2, 2'd2}, {2'd2, 2'd2, 2'd0, 2'd0},
    {2'd0, 2'd0, 2'd1, 2'd2}, {2'd1, 2'd1, 2'd2, 2'd0}, {2'd2, 2'd2, 2'd0, 2'd1},
    {2'd0, 2'd1, 2'd1, 2'd2}, {2'd1, 2'd2, 2'd2, 2'd0}, {2'd2, 2'd0, 2'd0, 2'd1}
  };

  function automatic logic [3:0] case_code(sign_e a, sign_e b, sign_e c);
    logic [4:0] idx;
    idx = 5'({3'b0, a} * 5'd9 + {3'b0, b} * 5'd3 + {3'b0, c});
    return CaseTable[idx];
  endfunction

endpackage

### design/conrec_contour_segments.sv
// Top level of the contour segment generator: configuration registers and wiring
// of front end, cell queue and segment engine. Depends on conrec_pkg and all submodules.
`timescale 1ns / 1ps

// Contour segment generator. Samples come in raster order, one word per
// accepted handshake; first_of_image_i restarts at column 0, row 0. A line
// store keeps the previous row, so every sample from the second row and column
// on closes a 2x2 cell. Cells with a non-finite corner give nothing. For each
// level in use that lies within the cell, the cell is cut into four triangles
// around the mean centre and each triangle gives at most one segment; endpoints
// come out with 8 fractional bits, floored, in level then triangle order, and
// last_o marks the final segment of a sample.
// Timing: the front end reads the line store on intake, then writes it back once
// the cell is handed on, and takes the next sample only after that and only while
// the cell queue (4 cells) has room. The segment engine fetches each cell, then
// classifies the triangles of one active level at a time, picks each segment and
// computes its two endpoints in turn in the shared restoring divider (10 quotient
// bits per endpoint) before it registers the output word. Sustained rate is set by
// the front end or the level scan, whichever is slower, and by the emitted segments.
// Config registers sit at byte address 4*i: row_width, level_count,
// level_0..level_5. Write them only while idle.

module conrec_contour_segments #(
  parameter int FifoDepth = conrec_pkg::CellFifoDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // sample channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic signed [conrec_pkg::SampleBits-1:0] sample_i,
  input  logic        sample_finite_i,
  input  logic        first_of_image_i,
  // segment channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [conrec_pkg::CoordBits-1:0]    x_start_o,
  output logic [conrec_pkg::CoordBits-1:0]    y_start_o,
  output logic [conrec_pkg::CoordBits-1:0]    x_end_o,
  output logic [conrec_pkg::CoordBits-1:0]    y_end_o,
  output logic [conrec_pkg::LevelIdxBits-1:0] level_index_o,
  output logic        last_o,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] RegRowWidth   = 3'd0;
  localparam logic [2:0] RegLevelCount = 3'd1;
  localparam logic [2:0] RegLevel0     = 3'd2;

  logic [conrec_pkg::WidthBits-1:0] row_width_q;
  conrec_pkg::cfg_t cfg_q;
  logic [2:0] reg_idx;
  logic [2:0] lev_sel;
  logic       wr_en;

  logic              push, full, pop, empty;
  conrec_pkg::cell_t cell_in, cell_out;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign lev_sel = reg_idx - RegLevel0;
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= conrec_pkg::WidthBits'(conrec_pkg::MaxCols);
      cfg_q       <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegRowWidth:   row_width_q       <= pwdata[conrec_pkg::WidthBits-1:0];
        RegLevelCount: cfg_q.level_count <= pwdata[conrec_pkg::CountBits-1:0];
        default:       cfg_q.levels[lev_sel] <= pwdata[conrec_pkg::SampleBits-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegRowWidth:   prdata = 32'(row_width_q);
      RegLevelCount: prdata = 32'(cfg_q.level_count);
      default:       prdata = 32'(cfg_q.levels[lev_sel]);
    endcase
  end

  conrec_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_i         (sample_i),
    .sample_finite_i  (sample_finite_i),
    .first_of_image_i (first_of_image_i),
    .row_width_i      (row_width_q),
    .push_o           (push),
    .cell_o           (cell_in),
    .full_i           (full)
  );

  conrec_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cell_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (cell_out),
    .empty_o (empty)
  );

  conrec_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .empty_i       (empty),
    .cell_i        (cell_out),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .x_start_o     (x_start_o),
    .y_start_o     (y_start_o),
    .x_end_o       (x_end_o),
    .y_end_o       (y_end_o),
    .level_index_o (level_index_o),
    .last_o        (last_o)
  );

endmodule

### design/conrec_front.sv
// Front end: sample intake, row position tracking, line store, cell forming.
// Depends on conrec_pkg.
`timescale 1ns / 1ps

module conrec_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  conrec_pkg::sample_t              sample_i,
  input  logic                             sample_finite_i,
  input  logic                             first_of_image_i,
  input  logic [conrec_pkg::WidthBits-1:0] row_width_i,
  output logic                             push_o,
  output conrec_pkg::cell_t                cell_o,
  input  logic                             full_i
);

  typedef struct packed {
    logic                fin;
    conrec_pkg::sample_t val;
  } stored_t;

  typedef enum logic {FeIdle, FeLook} state_e;

  state_e state_q;
  logic [conrec_pkg::ColBits-1:0] col_q, pcol_q;
  logic [conrec_pkg::RowBits-1:0] row_q, prow_q;
  stored_t left_q, ul_q, cur_q, up_q;
  stored_t store_q [conrec_pkg::MaxCols];

  logic [conrec_pkg::WidthBits-1:0] width;
  logic [conrec_pkg::ColBits-1:0]   colc, col_use;
  logic [conrec_pkg::RowBits-1:0]   rowc;
  logic [conrec_pkg::WidthBits-1:0] ncol;
  logic accept, cell_ok, go;

  always_comb begin
    if (row_width_i < conrec_pkg::WidthBits'(2)) begin
      width = conrec_pkg::WidthBits'(2);
    end else if (row_width_i > conrec_pkg::WidthBits'(conrec_pkg::MaxCols)) begin
      width = conrec_pkg::WidthBits'(conrec_pkg::MaxCols);
    end else begin
      width = row_width_i;
    end
  end

  assign in_stall_o = (state_q != FeIdle);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    colc = first_of_image_i ? '0 : col_q;
    rowc = first_of_image_i ? '0 : row_q;
    if (conrec_pkg::WidthBits'(colc) >= width) begin
      col_use = conrec_pkg::ColBits'(width - conrec_pkg::WidthBits'(1));
    end else begin
      col_use = colc;
    end
  end

  assign cell_ok = (pcol_q != '0) && (prow_q != '0) &&
                   (prow_q < conrec_pkg::RowBits'(conrec_pkg::MaxRows)) &&
                   ul_q.fin && up_q.fin && cur_q.fin && left_q.fin;
  assign go     = (state_q == FeLook) && (!cell_ok || !full_i);
  assign push_o = go && cell_ok;
  assign ncol   = conrec_pkg::WidthBits'(pcol_q) + conrec_pkg::WidthBits'(1);

  always_comb begin
    cell_o.s1 = ul_q.val;
    cell_o.s2 = up_q.val;
    cell_o.s3 = cur_q.val;
    cell_o.s4 = left_q.val;
    cell_o.ci = pcol_q - conrec_pkg::ColBits'(1);
    cell_o.cj = conrec_pkg::RowIdxBits'(prow_q - conrec_pkg::RowBits'(1));
  end

  // line store: read on intake, written once the cell is handed on or dropped
  always_ff @(posedge clk_i) begin
    if (accept) begin
      up_q <= store_q[col_use];
    end
    if (go) begin
      store_q[pcol_q] <= cur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FeIdle;
      col_q   <= '0;
      row_q   <= '0;
      left_q  <= '0;
      ul_q    <= '0;
      cur_q   <= '0;
      pcol_q  <= '0;
      prow_q  <= '0;
    end else begin
      unique case (state_q)
        FeIdle: begin
          if (accept) begin
            cur_q.val <= sample_i;
            cur_q.fin <= sample_finite_i;
            pcol_q    <= col_use;
            prow_q    <= rowc;
            state_q   <= FeLook;
          end
        end
        FeLook: begin
          if (go) begin
            ul_q   <= up_q;
            left_q <= cur_q;
            if (ncol >= width) begin
              col_q <= '0;
              row_q <= (prow_q < conrec_pkg::RowBits'(conrec_pkg::MaxRows)) ?
                       prow_q + conrec_pkg::RowBits'(1) : prow_q;
            end else begin
              col_q <= conrec_pkg::ColBits'(ncol);
              row_q <= prow_q;
            end
            state_q <= FeIdle;
          end
        end
        default: state_q <= FeIdle;
      endcase
    end
  end

endmodule

### design/conrec_fifo.sv
// Short queue of formed cells between the front end and the segment engine.
// Depends on conrec_pkg.
`timescale 1ns / 1ps

module conrec_fifo #(
  parameter int Depth = conrec_pkg::CellFifoDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  conrec_pkg::cell_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output conrec_pkg::cell_t data_o,
  output logic              empty_o
);

  localparam int PtrBits = $clog2(Depth);

  conrec_pkg::cell_t mem_q [Depth];
  logic [PtrBits-1:0] wr_q, rd_q;
  logic [PtrBits:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrBits+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrBits'(Depth - 1)) ? '0 : wr_q + PtrBits'(1);
      if (pop_i)  rd_q <= (rd_q == PtrBits'(Depth - 1)) ? '0 : rd_q + PtrBits'(1);
      cnt_q <= cnt_q + (PtrBits+1)'(push_i) - (PtrBits+1)'(pop_i);
    end
  end

endmodule

### design/conrec_back.sv
// Segment engine: level scan, triangle case lookup, endpoint division, output word.
// Depends on conrec_pkg.
`timescale 1ns / 1ps

module conrec_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  conrec_pkg::cfg_t                  cfg_i,
  input  logic                              empty_i,
  input  conrec_pkg::cell_t                 cell_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [conrec_pkg::CoordBits-1:0]  x_start_o,
  output logic [conrec_pkg::CoordBits-1:0]  y_start_o,
  output logic [conrec_pkg::CoordBits-1:0]  x_end_o,
  output logic [conrec_pkg::CoordBits-1:0]  y_end_o,
  output logic [conrec_pkg::LevelIdxBits-1:0] level_index_o,
  output logic                              last_o
);

  localparam int HW      = conrec_pkg::SampleBits + 5;
  localparam int QuoBits = conrec_pkg::FracBits + 2;
  localparam int RW      = HW + QuoBits - 1;
  localparam int CW      = conrec_pkg::CoordBits + 3;
  localparam int CntBits = $clog2(QuoBits);

  typedef enum logic [2:0] {BkIdle, BkScan, BkPick, BkSetup, BkDiv, BkFin, BkEmit} state_e;

  state_e state_q;
  conrec_pkg::cell_t cell_q;
  logic [conrec_pkg::LevelIdxBits-1:0] scan_k_q, seg_k_q, lvl, nlev;
  logic [3:0] cv_q [conrec_pkg::SlotCount];
  logic [1:0] seg_t_q;
  logic [3:0] seg_cv_q;
  logic       last_q, phase_q;
  logic [RW-1:0] rem_q, dsh_q;
  logic [QuoBits-1:0] quo_q;
  logic [CntBits-1:0] cnt_q;
  logic sgn_q, dzero_q;
  logic signed [2:0] dcx_q, dcy_q;
  logic [1:0] px_q, py_q;
  logic [conrec_pkg::CoordBits-1:0] xa_q, ya_q, xb_q, yb_q;
  logic [conrec_pkg::CoordBits-1:0] ox_q, oy_q, ex_q, ey_q;
  logic [conrec_pkg::LevelIdxBits-1:0] lev_out_q;
  logic out_valid_q, out_last_q;

  conrec_pkg::sample_t z;
  logic signed [conrec_pkg::SampleBits:0] d [1:4];
  logic signed [HW-1:0] h [5];
  conrec_pkg::sign_e sg [5];
  logic in_range;
  logic [3:0] code [conrec_pkg::TriCount];
  logic pick_any, pick_last;
  logic [conrec_pkg::SlotBits-1:0] pick_idx;
  logic [7:0] ent;
  logic [1:0] lp, lq;
  logic [2:0] gp, gq;
  logic signed [HW-1:0] hp, hq;
  logic signed [HW:0] den;
  logic [HW-1:0] nabs;
  logic [HW:0] dabs;
  logic rem_nz;
  logic [conrec_pkg::CoordBits-1:0] cx, cy;

  function automatic logic [2:0] glob(logic [1:0] l, logic [1:0] t);
    logic [2:0] g;
    unique case (l)
      2'd0:    g = 3'(t) + 3'd1;
      2'd1:    g = 3'd0;
      default: g = (t == 2'd3) ? 3'd1 : 3'(t) + 3'd2;
    endcase
    return g;
  endfunction

  // vertex offsets in half cells: centre is vertex 0
  function automatic logic [1:0] offx(logic [2:0] v);
    logic [1:0] o;
    case (v)
      3'd0:    o = 2'd1;
      3'd2:    o = 2'd2;
      3'd3:    o = 2'd2;
      default: o = 2'd0;
    endcase
    return o;
  endfunction

  function automatic logic [1:0] offy(logic [2:0] v);
    logic [1:0] o;
    case (v)
      3'd0:    o = 2'd1;
      3'd3:    o = 2'd2;
      3'd4:    o = 2'd2;
      default: o = 2'd0;
    endcase
    return o;
  endfunction

  function automatic logic [conrec_pkg::CoordBits-1:0] coord(
      logic [conrec_pkg::ColBits-1:0] base, logic [1:0] off, logic signed [2:0] dc,
      logic [QuoBits-1:0] q, logic rnz, logic sgn, logic dz);
    logic [QuoBits-1:0] mag;
    logic inex, neg;
    logic signed [CW-1:0] pos, delta, sum;
    pos = CW'({base, conrec_pkg::FracBits'(0)}) +
          CW'({off, (conrec_pkg::FracBits-1)'(0)});
    mag  = dc[0] ? (q >> 1) : q;
    inex = dc[0] ? (q[0] | rnz) : rnz;
    neg  = dc[2] ^ sgn;
    if (dc == 3'sd0 || dz) begin
      delta = '0;
    end else if (neg) begin
      delta = -(CW'(mag) + CW'(inex));
    end else begin
      delta = CW'(mag);
    end
    sum = pos + delta;
    return sum[conrec_pkg::CoordBits-1:0];
  endfunction

  assign nlev = (cfg_i.level_count > conrec_pkg::LevelIdxBits'(conrec_pkg::MaxLevels)) ?
                conrec_pkg::LevelIdxBits'(conrec_pkg::MaxLevels) : cfg_i.level_count;
  assign lvl  = (state_q == BkScan) ? scan_k_q : seg_k_q;
  assign z    = cfg_i.levels[lvl];

  // heights of corners (times four) and of the centre for the selected level
  always_comb begin
    d[1] = {cell_q.s1[conrec_pkg::SampleBits-1], cell_q.s1} - {z[conrec_pkg::SampleBits-1], z};
    d[2] = {cell_q.s2[conrec_pkg::SampleBits-1], cell_q.s2} - {z[conrec_pkg::SampleBits-1], z};
    d[3] = {cell_q.s3[conrec_pkg::SampleBits-1], cell_q.s3} - {z[conrec_pkg::SampleBits-1], z};
    d[4] = {cell_q.s4[conrec_pkg::SampleBits-1], cell_q.s4} - {z[conrec_pkg::SampleBits-1], z};
    h[0] = HW'(d[1]) + HW'(d[2]) + HW'(d[3]) + HW'(d[4]);
    for (int m = 1; m <= 4; m++) begin
      h[m] = HW'(d[m]) <<< 2;
    end
    for (int m = 0; m <= 4; m++) begin
      sg[m] = (h[m] > 0) ? conrec_pkg::SgPos :
              ((h[m] < 0) ? conrec_pkg::SgNeg : conrec_pkg::SgZero);
    end
    in_range = !(sg[1] == conrec_pkg::SgPos && sg[2] == conrec_pkg::SgPos &&
                 sg[3] == conrec_pkg::SgPos && sg[4] == conrec_pkg::SgPos) &&
               !(sg[1] == conrec_pkg::SgNeg && sg[2] == conrec_pkg::SgNeg &&
                 sg[3] == conrec_pkg::SgNeg && sg[4] == conrec_pkg::SgNeg);
    for (int t = 0; t < conrec_pkg::TriCount; t++) begin
      code[t] = in_range ?
                conrec_pkg::case_code(sg[t+1], sg[0], sg[(t == 3) ? 1 : t + 2]) : 4'd0;
    end
  end

  // lowest pending slot, and whether it is the cell's final one
  always_comb begin
    pick_any  = 1'b0;
    pick_idx  = '0;
    pick_last = 1'b1;
    for (int n = conrec_pkg::SlotCount - 1; n >= 0; n--) begin
      if (cv_q[n] != 4'd0) begin
        pick_any = 1'b1;
        pick_idx = conrec_pkg::SlotBits'(n);
      end
    end
    for (int n = 0; n < conrec_pkg::SlotCount; n++) begin
      if (cv_q[n] != 4'd0 && conrec_pkg::SlotBits'(n) != pick_idx) pick_last = 1'b0;
    end
  end

  always_comb begin
    ent  = conrec_pkg::SegTable[seg_cv_q];
    lp   = phase_q ? ent[3:2] : ent[7:6];
    lq   = phase_q ? ent[1:0] : ent[5:4];
    gp   = glob(lp, seg_t_q);
    gq   = glob(lq, seg_t_q);
    hp   = h[gp];
    hq   = h[gq];
    den  = {hp[HW-1], hp} - {hq[HW-1], hq};
    nabs = hp[HW-1] ? HW'(-hp) : HW'(hp);
    dabs = den[HW] ? (HW+1)'(-den) : (HW+1)'(den);
    rem_nz = (rem_q != '0);
    cx = coord(cell_q.ci, px_q, dcx_q, quo_q, rem_nz, sgn_q, dzero_q);
    cy = coord(cell_q.cj, py_q, dcy_q, quo_q, rem_nz, sgn_q, dzero_q);
  end

  assign pop_o = (state_q == BkIdle) && !empty_i;

  assign out_valid_o   = out_valid_q;
  assign x_start_o     = ox_q;
  assign y_start_o     = oy_q;
  assign x_end_o       = ex_q;
  assign y_end_o       = ey_q;
  assign level_index_o = lev_out_q;
  assign last_o        = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      out_valid_q <= 1'b0;
      scan_k_q    <= '0;
      phase_q     <= 1'b0;
      cnt_q       <= '0;
    end else begin
      // the emit state reloads the output word itself
      if (out_valid_q && !out_stall_i && state_q != BkEmit) out_valid_q <= 1'b0;
      unique case (state_q)
        BkIdle: begin
          if (!empty_i) begin
            cell_q   <= cell_i;
            scan_k_q <= '0;
            for (int n = 0; n < conrec_pkg::SlotCount; n++) cv_q[n] <= 4'd0;
            state_q  <= (nlev == '0) ? BkPick : BkScan;
          end
        end
        BkScan: begin
          for (int t = 0; t < conrec_pkg::TriCount; t++) begin
            cv_q[{scan_k_q, 2'(t)}] <= code[t];
          end
          if (scan_k_q == nlev - conrec_pkg::LevelIdxBits'(1)) begin
            state_q <= BkPick;
          end else begin
            scan_k_q <= scan_k_q + conrec_pkg::LevelIdxBits'(1);
          end
        end
        BkPick: begin
          if (pick_any) begin
            seg_k_q        <= pick_idx[conrec_pkg::SlotBits-1:2];
            seg_t_q        <= pick_idx[1:0];
            seg_cv_q       <= cv_q[pick_idx];
            last_q         <= pick_last;
            cv_q[pick_idx] <= 4'd0;
            phase_q        <= 1'b0;
            state_q        <= BkSetup;
          end else begin
            state_q <= BkIdle;
          end
        end
        BkSetup: begin
          rem_q   <= RW'(nabs) << conrec_pkg::FracBits;
          dsh_q   <= RW'(dabs) << (QuoBits - 1);
          quo_q   <= '0;
          cnt_q   <= '0;
          sgn_q   <= hp[HW-1] ^ den[HW];
          dzero_q <= (den == '0);
          px_q    <= offx(gp);
          py_q    <= offy(gp);
          dcx_q   <= $signed({1'b0, offx(gq)}) - $signed({1'b0, offx(gp)});
          dcy_q   <= $signed({1'b0, offy(gq)}) - $signed({1'b0, offy(gp)});
          state_q <= BkDiv;
        end
        BkDiv: begin
          if (rem_q >= dsh_q) begin
            rem_q <= rem_q - dsh_q;
            quo_q <= {quo_q[QuoBits-2:0], 1'b1};
          end else begin
            quo_q <= {quo_q[QuoBits-2:0], 1'b0};
          end
          dsh_q <= dsh_q >> 1;
          cnt_q <= cnt_q + CntBits'(1);
          if (cnt_q == CntBits'(QuoBits - 1)) state_q <= BkFin;
        end
        BkFin: begin
          if (!phase_q) begin
            xa_q    <= cx;
            ya_q    <= cy;
            phase_q <= 1'b1;
            state_q <= BkSetup;
          end else begin
            xb_q    <= cx;
            yb_q    <= cy;
            state_q <= BkEmit;
          end
        end
        BkEmit: begin
          if (!out_valid_q || !out_stall_i) begin
            ox_q        <= xa_q;
            oy_q        <= ya_q;
            ex_q        <= xb_q;
            ey_q        <= yb_q;
            lev_out_q   <= seg_k_q;
            out_last_q  <= last_q;
            out_valid_q <= 1'b1;
            state_q     <= BkPick;
          end
        end
        default: state_q <= BkIdle;
      endcase
    end
  end

endmodule

### tb/conrec_checker.sv
// Checker for conrec_contour_segments: tracks config writes, predicts segments per sample word.
// Depends on conrec_pkg for widths; compares every accepted segment word in order.
`timescale 1ns / 1ps

module conrec_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic signed [conrec_pkg::SampleBits-1:0] sample_i,
  input  logic        sample_finite_i,
  input  logic        first_of_image_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [conrec_pkg::CoordBits-1:0]    x_start_i,
  input  logic [conrec_pkg::CoordBits-1:0]    y_start_i,
  input  logic [conrec_pkg::CoordBits-1:0]    x_end_i,
  input  logic [conrec_pkg::CoordBits-1:0]    y_end_i,
  input  logic [conrec_pkg::LevelIdxBits-1:0] level_index_i,
  input  logic        last_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o,
  output int          seg_count_o,
  output int          word_count_o
);

  localparam int RegRowWidth = 0;
  localparam int RegLevelCount = 1;
  localparam int RegLevel0 = 2;

  typedef struct packed {
    logic [conrec_pkg::CoordBits-1:0]    xs;
    logic [conrec_pkg::CoordBits-1:0]    ys;
    logic [conrec_pkg::CoordBits-1:0]    xe;
    logic [conrec_pkg::CoordBits-1:0]    ye;
    logic [conrec_pkg::LevelIdxBits-1:0] lvl;
    logic                                last;
  } seg_t;

  typedef struct packed {
    logic                fin;
    conrec_pkg::sample_t val;
  } px_t;

  // triangle sign triple -> case, case -> endpoint edges
  localparam int SignCase [27] = '{0, 0, 8, 0, 2, 5, 7, 6, 9,
                                   0, 3, 4, 1, 3, 1, 4, 3, 0,
                                   9, 6, 7, 5, 2, 0, 8, 0, 0};
  localparam int EdgeSel [10][4] = '{'{0, 0, 0, 0}, '{0, 0, 1, 1}, '{1, 1, 2, 2},
                                     '{2, 2, 0, 0}, '{0, 0, 1, 2}, '{1, 1, 2, 0},
                                     '{2, 2, 0, 1}, '{0, 1, 1, 2}, '{1, 2, 2, 0},
                                     '{2, 0, 0, 1}};

  seg_t                seg_q[$];
  px_t                 line_mem [conrec_pkg::MaxCols];
  px_t                 left_px, ul_px;
  int unsigned         col_pos, row_pos;
  logic [12:0]         row_width;
  logic [2:0]          level_count;
  conrec_pkg::sample_t levels [conrec_pkg::MaxLevels];
  int                  fails, segs, words;

  assign fail_count_o = fails;
  assign pending_o    = seg_q.size();
  assign seg_count_o  = segs;
  assign word_count_o = words;

  function automatic longint cross_pt(longint h[5], longint c[5], int p, int q);
    longint num, den, quo;
    num = (c[q] - c[p]) * h[p];
    den = h[p] - h[q];
    if (den == 0) return c[p];
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    quo = num / den;
    if (num % den != 0 && num < 0) quo--;
    return c[p] + quo;
  endfunction

  function automatic int sgn(longint v);
    return v > 0 ? 2 : (v < 0 ? 0 : 1);
  endfunction

  task automatic predict_segments(conrec_pkg::sample_t smp, logic fin, logic foi);
    px_t cur, up;
    int unsigned col, row, width, nlev;
    longint s[5], xs[5], ys[5], h[5], dmin, dmax, z;
    int sg[5], v[3], cv, cnt, first_idx;
    seg_t sg_w;
    cur.val = smp;
    cur.fin = fin;
    cnt = 0;
    first_idx = seg_q.size();
    if (foi) begin
      col_pos = 0;
      row_pos = 0;
    end
    col = col_pos;
    row = row_pos;
    width = row_width < 2 ? 2 :
            (row_width > conrec_pkg::MaxCols ? conrec_pkg::MaxCols : row_width);
    if (col >= width) col = width - 1;
    up = line_mem[col];
    if (col >= 1 && row >= 1 && row < conrec_pkg::MaxRows && ul_px.fin && up.fin &&
        cur.fin && left_px.fin) begin
      s[1] = ul_px.val;
      s[2] = up.val;
      s[3] = cur.val;
      s[4] = left_px.val;
      xs[1] = longint'(col - 1) << conrec_pkg::FracBits;
      xs[4] = xs[1];
      xs[2] = longint'(col) << conrec_pkg::FracBits;
      xs[3] = xs[2];
      ys[1] = longint'(row - 1) << conrec_pkg::FracBits;
      ys[2] = ys[1];
      ys[3] = longint'(row) << conrec_pkg::FracBits;
      ys[4] = ys[3];
      xs[0] = xs[1] + (1 << (conrec_pkg::FracBits - 1));
      ys[0] = ys[1] + (1 << (conrec_pkg::FracBits - 1));
      dmin = s[1];
      dmax = s[1];
      for (int m = 2; m <= 4; m++) begin
        if (s[m] < dmin) dmin = s[m];
        if (s[m] > dmax) dmax = s[m];
      end
      nlev = level_count > conrec_pkg::MaxLevels ? conrec_pkg::MaxLevels : level_count;
      for (int k = 0; k < nlev; k++) begin
        z = levels[k];
        if (z < dmin || z > dmax) continue;
        h[0] = 0;
        for (int m = 1; m <= 4; m++) begin
          h[m] = 4 * (s[m] - z);
          h[0] += s[m] - z;
        end
        for (int m = 0; m <= 4; m++) sg[m] = sgn(h[m]);
        for (int m = 1; m <= 4; m++) begin
          v[0] = m;
          v[1] = 0;
          v[2] = (m == 4) ? 1 : m + 1;
          cv = SignCase[sg[v[0]] * 9 + sg[v[1]] * 3 + sg[v[2]]];
          if (cv == 0) continue;
          sg_w.xs = conrec_pkg::CoordBits'(
                      cross_pt(h, xs, v[EdgeSel[cv][0]], v[EdgeSel[cv][1]]));
          sg_w.ys = conrec_pkg::CoordBits'(
                      cross_pt(h, ys, v[EdgeSel[cv][0]], v[EdgeSel[cv][1]]));
          sg_w.xe = conrec_pkg::CoordBits'(
                      cross_pt(h, xs, v[EdgeSel[cv][2]], v[EdgeSel[cv][3]]));
          sg_w.ye = conrec_pkg::CoordBits'(
                      cross_pt(h, ys, v[EdgeSel[cv][2]], v[EdgeSel[cv][3]]));
          sg_w.lvl = conrec_pkg::LevelIdxBits'(k);
          sg_w.last = 1'b0;
          seg_q.insert(seg_q.size(), sg_w);
          cnt++;
        end
      end
      if (cnt > 0) seg_q[first_idx + cnt - 1].last = 1'b1;
    end
    line_mem[col] = cur;
    ul_px = up;
    left_px = cur;
    col++;
    if (col >= width) begin
      col = 0;
      if (row < conrec_pkg::MaxRows) row++;
    end
    col_pos = col;
    row_pos = row;
  endtask

  initial begin
    for (int i = 0; i < conrec_pkg::MaxCols; i++) line_mem[i] = '0;
    left_px = '0;
    ul_px = '0;
    col_pos = 0;
    row_pos = 0;
    row_width = 13'd4096;
    level_count = '0;
    for (int i = 0; i < conrec_pkg::MaxLevels; i++) levels[i] = '0;
    fails = 0;
    segs = 0;
    words = 0;
  end

  always @(posedge clk_i) begin
    seg_t exp_w;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready) begin
        case (int'(paddr >> 2))
          RegRowWidth:   row_width = pwdata[12:0];
          RegLevelCount: level_count = pwdata[2:0];
          default: if (int'(paddr >> 2) >= RegLevel0 &&
                       int'(paddr >> 2) < RegLevel0 + conrec_pkg::MaxLevels)
            levels[int'(paddr >> 2) - RegLevel0] = pwdata[15:0];
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        words++;
        predict_segments(sample_i, sample_finite_i, first_of_image_i);
      end
      if (out_valid_i && !out_stall_i) begin
        segs++;
        if (seg_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("segment word with none expected: x0=%0d y0=%0d",
                                    x_start_i, y_start_i);
        end else begin
          exp_w = seg_q.pop_front();
          if (exp_w.xs !== x_start_i || exp_w.ys !== y_start_i || exp_w.xe !== x_end_i ||
              exp_w.ye !== y_end_i || exp_w.lvl !== level_index_i || exp_w.last !== last_i)
          begin
            fails++;
            if (fails <= 10)
              $display({"mismatch exp (%0d,%0d)-(%0d,%0d) l%0d last%0b ",
                        "got (%0d,%0d)-(%0d,%0d) l%0d last%0b"},
                       exp_w.xs, exp_w.ys, exp_w.xe, exp_w.ye, exp_w.lvl, exp_w.last,
                       x_start_i, y_start_i, x_end_i, y_end_i, level_index_i, last_i);
          end
        end
      end
    end
  end

endmodule

### tb/tb_top.sv
// Top of the conrec_contour_segments testbench: clock, reset, stimulus and verdict.
// Depends on conrec_pkg, the block itself and conrec_checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int RegRowWidth = 0;
  localparam int RegLevelCount = 1;
  localparam int RegLevel0 = 2;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [conrec_pkg::SampleBits-1:0] sample = '0;
  logic sample_finite = 1'b0;
  logic first_of_image = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [conrec_pkg::CoordBits-1:0] x_start, y_start, x_end, y_end;
  logic [conrec_pkg::LevelIdxBits-1:0] level_index;
  logic last;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  int fail_count, pending, seg_count, word_count;
  bit quiet = 1'b0;     // no idling on either side near the end
  int rand_words = 0;

  always #5 clk = ~clk;

  conrec_contour_segments u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .sample_i(sample), .sample_finite_i(sample_finite), .first_of_image_i(first_of_image),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .x_start_o(x_start), .y_start_o(y_start), .x_end_o(x_end), .y_end_o(y_end),
    .level_index_o(level_index), .last_o(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  conrec_checker u_chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .sample_i(sample), .sample_finite_i(sample_finite), .first_of_image_i(first_of_image),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .x_start_i(x_start), .y_start_i(y_start), .x_end_i(x_end), .y_end_i(y_end),
    .level_index_i(level_index), .last_i(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count_o(fail_count), .pending_o(pending),
    .seg_count_o(seg_count), .word_count_o(word_count)
  );

  // Receiver: stall in random bursts, long runs of no stall in between.
  initial begin
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #20ms;
    $display("conrec_contour_segments test failed");
    $finish;
  end

  // One APB write: setup cycle, then access cycle (pready is tied high).
  task automatic reg_write(int idx, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = 5'(idx * 4);
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Quiesce: all expected segments out, then let skipped cells drain.
  task automatic drain;
    in_valid = 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic set_config(int w, int n, int lv [6]);
    drain();
    reg_write(RegRowWidth, 32'(w));
    reg_write(RegLevelCount, 32'(n));
    for (int i = 0; i < conrec_pkg::MaxLevels; i++) reg_write(RegLevel0 + i, 32'(lv[i]));
  endtask

  // Send one sample word; random gaps before it unless quiet.
  task automatic send_word(int val, bit fin, bit foi);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid = 1'b1;
    sample = 16'(val);
    sample_finite = fin;
    first_of_image = foi;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  int lv [6];
  int dvals [24] = '{0, 5, 10, -5, -5, 5, 5, -5, -32768, 32767, 32767, -32768,
                     100, 100, 0, 0, 100, 7, -7, 3, 3, -3, 32767, -32768};
  bit dfin [24] = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
                    1, 1, 1, 1, 1, 1, 0, 1, 1, 1, 1, 1};

  initial begin
    int w, rows, n, base, spread, mode;
    bit last_phase;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed: width below range clamps to 2, level count above range uses six;
    // extremes, levels equal to corners, a non-finite corner.
    lv = '{-32768, 32767, 0, 5, -5, 100};
    set_config(1, 7, lv);
    for (int i = 0; i < 24; i++) send_word(dvals[i], dfin[i], i == 0);

    // Zero width, no levels: nothing comes out.
    lv = '{1, -1, 2, -2, 3, -3};
    set_config(0, 0, lv);
    for (int i = 0; i < 6; i++) send_word($urandom_range(0, 20), 1'b1, i == 0);

    // Widest row: a few samples along the first row.
    lv = '{0, 1, -1, 0, 0, 0};
    set_config(4096, 3, lv);
    for (int i = 0; i < 8; i++) send_word(int'($urandom_range(0, 6)) - 3, 1'b1, i == 0);

    // Register at its top code clamps to the widest row.
    set_config(8191, 1, lv);
    for (int i = 0; i < 8; i++) send_word(int'($urandom_range(0, 6)) - 3, 1'b1, i == 0);

    // Random phases: small images with levels drawn around the sample range.
    last_phase = 1'b0;
    while (!last_phase) begin
      last_phase = rand_words >= 320;
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(2, 9);
      rows = $urandom_range(3, 8);
      n = last_phase ? 6 : $urandom_range(0, 7);
      mode = $urandom_range(0, 3);
      base = int'($urandom_range(0, 65535)) - 32768;
      spread = $urandom_range(1, 400);
      for (int i = 0; i < conrec_pkg::MaxLevels; i++)
        lv[i] = (mode == 0) ? int'($urandom_range(0, 65535)) - 32768
                            : base + int'($urandom_range(0, 2 * spread)) - spread;
      set_config(w, n, lv);
      if (last_phase) quiet = 1'b1;
      for (int i = 0; i < w * rows; i++) begin
        int v;
        if (mode == 0) v = int'($urandom_range(0, 65535)) - 32768;
        else v = base + int'($urandom_range(0, 2 * spread)) - spread;
        send_word(v, $urandom_range(0, 31) != 0, i == 0 || $urandom_range(0, 49) == 0);
        rand_words++;
      end
    end

    in_valid = 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);

    $display("covered %0d sample words (%0d random) and %0d segment words",
             word_count, rand_words, seg_count);
    $display("widths 2..4096 with clamping, 0..7 levels, extremes, non-finite corners");
    if (fail_count == 0) begin
      $display("conrec_contour_segments test passed");
    end else begin
      $display("conrec_contour_segments test failed");
    end
    $finish;
  end

endmodule
